### hdl/dava_pkg.sv
// Shared types, constants and character helpers for the dual-channel averaging voltmeter.
package dava_pkg;

  localparam int SAMPLES_DEF  = 8;
  localparam int ADC_BITS_DEF = 12;

  localparam int FS_W   = 13;
  localparam int MV_W   = FS_W;
  localparam int HEX_W  = 12;
  localparam int CHAR_W = 8;

  localparam logic [FS_W-1:0] FS_RESET = 13'd3300;

  // Burst layout: clear, 9 channel A bytes, line 2, 9 channel B bytes.
  localparam int BURST_LEN  = 20;
  localparam int IDX_W      = 5;
  localparam int POS_W      = 4;
  localparam logic [IDX_W-1:0] IDX_CLEAR = 5'd0;
  localparam logic [IDX_W-1:0] IDX_LINE2 = 5'd10;
  localparam logic [IDX_W-1:0] IDX_LAST  = 5'(BURST_LEN - 1);

  localparam logic [CHAR_W-1:0] CMD_CLEAR     = 8'h01;
  localparam logic [CHAR_W-1:0] CMD_LINE2     = 8'hC0;
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_HEX_OFS = 8'h37;
  localparam logic [CHAR_W-1:0] ASCII_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;

  // Byte positions within one channel's nine characters
  localparam logic [POS_W-1:0] POS_VOLT  = 4'd0;
  localparam logic [POS_W-1:0] POS_COMMA = 4'd1;
  localparam logic [POS_W-1:0] POS_HUND  = 4'd2;
  localparam logic [POS_W-1:0] POS_TENS  = 4'd3;
  localparam logic [POS_W-1:0] POS_ONES  = 4'd4;
  localparam logic [POS_W-1:0] POS_SPACE = 4'd5;
  localparam logic [POS_W-1:0] POS_HEX2  = 4'd6;
  localparam logic [POS_W-1:0] POS_HEX1  = 4'd7;
  localparam logic [POS_W-1:0] POS_HEX0  = 4'd8;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_DIV,
    LN_MUL,
    LN_BCD,
    LN_DONE
  } dava_lane_state_t;

  typedef struct packed {
    logic [3:0]       thou;
    logic [3:0]       hund;
    logic [3:0]       tens;
    logic [3:0]       ones;
    logic [HEX_W-1:0] hex;
  } dava_lane_res_t;

  typedef struct packed {
    logic           busy;
    logic           valid;
    dava_lane_res_t res;
  } dava_lane_out_t;

  function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {4'b0000, nib};
    return (nib > 4'd9) ? ASCII_HEX_OFS + ext : ASCII_ZERO + ext;
  endfunction

  function automatic logic [CHAR_W-1:0] chan_byte(input logic [POS_W-1:0] pos,
                                                  input dava_lane_res_t r);
    logic [CHAR_W-1:0] b;
    case (pos)
      POS_VOLT:  b = hex_ascii(r.thou);
      POS_COMMA: b = ASCII_COMMA;
      POS_HUND:  b = hex_ascii(r.hund);
      POS_TENS:  b = hex_ascii(r.tens);
      POS_ONES:  b = hex_ascii(r.ones);
      POS_SPACE: b = ASCII_SPACE;
      POS_HEX2:  b = hex_ascii(r.hex[11:8]);
      POS_HEX1:  b = hex_ascii(r.hex[7:4]);
      POS_HEX0:  b = hex_ascii(r.hex[3:0]);
      default:   b = ASCII_SPACE;
    endcase
    return b;
  endfunction

endpackage

### hdl/dava_lane.sv
// One channel lane: running sum, reciprocal divide, millivolt scaling and BCD conversion.
module dava_lane #(
  parameter int SAMPLES_PER_AVERAGE = dava_pkg::SAMPLES_DEF,
  parameter int ADC_BITS            = dava_pkg::ADC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc_en,
  input  logic                       acc_last,
  input  logic [ADC_BITS-1:0]        sample,
  input  logic [dava_pkg::FS_W-1:0]  fs,
  input  logic                       take,
  output dava_pkg::dava_lane_out_t   lane_o
);
  import dava_pkg::*;

  localparam int LOG_N     = $clog2(SAMPLES_PER_AVERAGE);
  localparam int SUM_W     = ADC_BITS + LOG_N;
  localparam int RECIP_SH  = SUM_W + LOG_N;
  localparam int RECIP_W   = SUM_W + 1;
  localparam int QP_W      = SUM_W + RECIP_W;
  localparam int BCD_STEPS = (MV_W + 1) / 2;
  localparam int BIN_W     = 2 * BCD_STEPS;
  localparam int STEP_W    = $clog2(BCD_STEPS);
  localparam int PROD_W    = ADC_BITS + FS_W;
  // ceil(2^RECIP_SH / N): exact truncating quotient for every sum below 2^SUM_W
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(SAMPLES_PER_AVERAGE - 1)) /
             64'(SAMPLES_PER_AVERAGE));
  localparam logic [STEP_W-1:0]  BCD_LAST = STEP_W'(BCD_STEPS - 1);

  dava_lane_state_t state_r, state_nxt;

  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   final_sum;
  logic [SUM_W-1:0]   win_sum_r;
  logic [QP_W-1:0]    quot_prod;
  logic [ADC_BITS-1:0] avg_r;
  logic [STEP_W-1:0]  step_r;
  logic [15:0]        bcd_r, bcd_nxt;
  logic [BIN_W-1:0]   bin_r, bin_nxt;
  logic [PROD_W-1:0]  prod;
  logic [ADC_BITS+HEX_W-1:0] avg_ext;
  logic               start;

  assign start     = acc_en && acc_last;
  assign final_sum = sum_r + SUM_W'(sample);
  assign quot_prod = QP_W'(win_sum_r) * QP_W'(RECIP);
  assign prod      = PROD_W'(avg_r) * PROD_W'(fs);
  assign avg_ext   = {{HEX_W{1'b0}}, avg_r};

  // Double dabble, two shifts per cycle
  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    for (int k = 0; k < 2; k++) begin
      for (int d = 0; d < 4; d++) begin
        if (bcd_nxt[4*d +: 4] >= 4'd5) begin
          bcd_nxt[4*d +: 4] = bcd_nxt[4*d +: 4] + 4'd3;
        end
      end
      {bcd_nxt, bin_nxt} = {bcd_nxt[14:0], bin_nxt, 1'b0};
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      LN_IDLE: if (start) state_nxt = LN_DIV;
      LN_DIV:  state_nxt = LN_MUL;
      LN_MUL:  state_nxt = LN_BCD;
      LN_BCD:  if (step_r == '0) state_nxt = LN_DONE;
      LN_DONE: if (take) state_nxt = LN_IDLE;
      default: state_nxt = LN_IDLE;
    endcase
  end

  always_comb begin
    lane_o.busy     = (state_r != LN_IDLE);
    lane_o.valid    = (state_r == LN_DONE);
    lane_o.res.thou = bcd_r[15:12];
    lane_o.res.hund = bcd_r[11:8];
    lane_o.res.tens = bcd_r[7:4];
    lane_o.res.ones = bcd_r[3:0];
    lane_o.res.hex  = avg_ext[HEX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LN_IDLE;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (acc_en) begin
        sum_r <= acc_last ? '0 : final_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      LN_IDLE: begin
        if (start) begin
          win_sum_r <= final_sum;
        end
      end
      LN_DIV: begin
        avg_r <= quot_prod[RECIP_SH +: ADC_BITS];
      end
      LN_MUL: begin
        bin_r  <= BIN_W'(prod[ADC_BITS +: MV_W]);
        bcd_r  <= '0;
        step_r <= BCD_LAST;
      end
      LN_BCD: begin
        bcd_r  <= bcd_nxt;
        bin_r  <= bin_nxt;
        step_r <= step_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/dava_merge.sv
// Merge stage: takes both lane results and sends the 20-byte display burst.
module dava_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dava_pkg::dava_lane_out_t     lane_a,
  input  dava_pkg::dava_lane_out_t     lane_b,
  output logic                         take,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [dava_pkg::CHAR_W-1:0]  out_char_byte,
  output logic                         out_is_command,
  output logic                         out_last_of_run
);
  import dava_pkg::*;

  logic              active_r;
  logic [IDX_W-1:0]  idx_r;
  dava_lane_res_t    res_a_r, res_b_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              cmd_r, cmd_nxt;
  logic              last_r;
  logic              load_out;
  logic [IDX_W-1:0]  pos_a, pos_b;

  assign take     = !active_r && lane_a.valid && lane_b.valid;
  assign load_out = !out_valid_r || out_ready;
  assign pos_a    = idx_r - 5'd1;
  assign pos_b    = idx_r - (IDX_LINE2 + 5'd1);

  always_comb begin
    cmd_nxt = 1'b0;
    if (idx_r == IDX_CLEAR) begin
      char_nxt = CMD_CLEAR;
      cmd_nxt  = 1'b1;
    end else if (idx_r == IDX_LINE2) begin
      char_nxt = CMD_LINE2;
      cmd_nxt  = 1'b1;
    end else if (idx_r < IDX_LINE2) begin
      char_nxt = chan_byte(pos_a[POS_W-1:0], res_a_r);
    end else begin
      char_nxt = chan_byte(pos_b[POS_W-1:0], res_b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        active_r <= 1'b1;
        idx_r    <= IDX_CLEAR;
      end else if (active_r && load_out) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          active_r <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid_r <= active_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_a_r <= lane_a.res;
      res_b_r <= lane_b.res;
    end
    if (active_r && load_out) begin
      char_r <= char_nxt;
      cmd_r  <= cmd_nxt;
      last_r <= (idx_r == IDX_LAST);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_byte   = char_r;
  assign out_is_command  = cmd_r;
  assign out_last_of_run = last_r;

endmodule

### hdl/dual_adc_average_voltmeter_display.sv
// Dual-channel boxcar averager that writes volts and hex readings as display bytes.
//
// Input channel: one transfer carries a pair of converter samples. Each pair is
// added to a per-channel running sum; every SAMPLES_PER_AVERAGE-th pair closes
// the window and both lanes start on the averages while sums clear.
// Output channel: each transfer is one display byte. A window produces a burst
// of 20: clear command, channel A (volts, comma, three mV digits, space, three
// hex digits), second-line command, then channel B; last_of_run marks the end.
// Each lane averages with a constant reciprocal multiply, scales to millivolts,
// then converts to BCD two bits a cycle. Throughput: pairs that do not close a
// window transfer every cycle. The byte serializer limits the sustained rate.
// A closing pair waits while either lane is still busy or holds results.
// Reset (rst_n low, synchronous) clears the sums, the pair count and any burst
// in flight, and loads fs_r with 3300 mV.
// A stalled receiver holds the current byte; the lanes keep the next window's
// results and the input side stalls only when a further window closes.
module dual_adc_average_voltmeter_display #(
  parameter int SAMPLES_PER_AVERAGE = dava_pkg::SAMPLES_DEF,
  parameter int ADC_BITS            = dava_pkg::ADC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ADC_BITS-1:0]          in_sample_a,
  input  logic [ADC_BITS-1:0]          in_sample_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dava_pkg::CHAR_W-1:0]  out_char_byte,
  output logic                         out_is_command,
  output logic                         out_last_of_run,
  input  logic                         cfg_wr_en,
  input  logic [dava_pkg::FS_W-1:0]    cfg_wr_data
);
  import dava_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  logic [CNT_W-1:0] pair_cnt_r;
  logic [FS_W-1:0]  fs_r;
  logic             win_last;
  logic             accept;
  logic             take;
  dava_lane_out_t   lane_a, lane_b;

  assign win_last = (pair_cnt_r == CNT_LAST);
  assign in_ready = !(win_last && (lane_a.busy || lane_b.busy));
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_cnt_r <= '0;
      fs_r       <= FS_RESET;
    end else begin
      if (accept) begin
        pair_cnt_r <= win_last ? '0 : pair_cnt_r + 1'b1;
      end
      if (cfg_wr_en) begin
        fs_r <= cfg_wr_data;
      end
    end
  end

  dava_lane #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .ADC_BITS            (ADC_BITS)
  ) u_lane_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_en   (accept),
    .acc_last (win_last),
    .sample   (in_sample_a),
    .fs       (fs_r),
    .take     (take),
    .lane_o   (lane_a)
  );

  dava_lane #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .ADC_BITS            (ADC_BITS)
  ) u_lane_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_en   (accept),
    .acc_last (win_last),
    .sample   (in_sample_b),
    .fs       (fs_r),
    .take     (take),
    .lane_o   (lane_b)
  );

  dava_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .lane_a          (lane_a),
    .lane_b          (lane_b),
    .take            (take),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_char_byte   (out_char_byte),
    .out_is_command  (out_is_command),
    .out_last_of_run (out_last_of_run)
  );

endmodule
